// ===== rtl/u8d_pkg.sv =====
// Package for the UTF-8 DFA decoder: state codes, item and result types,
// byte class and transition tables. No dependencies.
package u8d_pkg;

  localparam int unsigned StateW    = 4;
  localparam int unsigned ClassW    = 4;
  localparam int unsigned CpW       = 32;
  localparam int unsigned NumStates = 9;
  localparam int unsigned NumClass  = 16;

  localparam logic [StateW-1:0] AcceptState = 4'd0;
  localparam logic [StateW-1:0] RejectState = 4'd1;

  localparam logic [ClassW-1:0] ClsAscii  = 4'd0;
  localparam logic [ClassW-1:0] ClsCont1  = 4'd1;
  localparam logic [ClassW-1:0] ClsLead2  = 4'd2;
  localparam logic [ClassW-1:0] ClsLead3  = 4'd3;
  localparam logic [ClassW-1:0] ClsLeadED = 4'd4;
  localparam logic [ClassW-1:0] ClsLeadF4 = 4'd5;
  localparam logic [ClassW-1:0] ClsLead4  = 4'd6;
  localparam logic [ClassW-1:0] ClsCont3  = 4'd7;
  localparam logic [ClassW-1:0] ClsBad    = 4'd8;
  localparam logic [ClassW-1:0] ClsCont2  = 4'd9;
  localparam logic [ClassW-1:0] ClsLeadE0 = 4'hA;
  localparam logic [ClassW-1:0] ClsLeadF0 = 4'hB;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } u8d_item_t;

  typedef struct packed {
    logic [StateW-1:0] dfa_state;
    logic [CpW-1:0]    code_point;
    logic              code_point_done;
    logic              rejected;
    logic              string_valid;
  } u8d_res_t;

  typedef logic [StateW-1:0] u8d_row_t [NumClass];

  localparam u8d_row_t NextState [NumStates] = '{
    '{4'd0,4'd1,4'd2,4'd3,4'd5,4'd8,4'd7,4'd1,4'd1,4'd1,4'd4,4'd6,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd0,4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1}
  };

  function automatic logic [ClassW-1:0] byte_class(input logic [7:0] b);
    logic [ClassW-1:0] cls;
    priority if (b <= 8'h7F) cls = ClsAscii;
    else if (b <= 8'h8F)     cls = ClsCont1;
    else if (b <= 8'h9F)     cls = ClsCont2;
    else if (b <= 8'hBF)     cls = ClsCont3;
    else if (b <= 8'hC1)     cls = ClsBad;
    else if (b <= 8'hDF)     cls = ClsLead2;
    else if (b == 8'hE0)     cls = ClsLeadE0;
    else if (b == 8'hED)     cls = ClsLeadED;
    else if (b <= 8'hEF)     cls = ClsLead3;
    else if (b == 8'hF0)     cls = ClsLeadF0;
    else if (b <= 8'hF3)     cls = ClsLead4;
    else if (b == 8'hF4)     cls = ClsLeadF4;
    else                     cls = ClsBad;
    return cls;
  endfunction

  function automatic logic [StateW-1:0] next_state(input logic [StateW-1:0] st,
                                                   input logic [ClassW-1:0] cls);
    logic [StateW-1:0] ns;
    if (st < StateW'(NumStates)) begin
      ns = NextState[st][cls];
    end else begin
      ns = RejectState;
    end
    return ns;
  endfunction

endpackage

// ===== rtl/u8d_if.sv =====
// Channel interfaces for the UTF-8 DFA decoder: byte items in, results out.
// Depends on u8d_pkg.
interface u8d_in_if import u8d_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface u8d_out_if import u8d_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [StateW-1:0] dfa_state;
  logic [CpW-1:0]    code_point;
  logic              code_point_done;
  logic              rejected;
  logic              string_valid;

  modport source (output valid, dfa_state, code_point, code_point_done, rejected,
                  string_valid, input ready);
  modport sink   (input valid, dfa_state, code_point, code_point_done, rejected,
                  string_valid, output ready);
endinterface

// ===== rtl/u8d_step.sv =====
// One decoder step: byte class lookup, transition, code point accumulation.
// Depends on u8d_pkg.
module u8d_step import u8d_pkg::*; (
  input  logic [StateW-1:0] state_i,
  input  logic [CpW-1:0]    acc_i,
  input  u8d_item_t         item_i,
  output u8d_res_t          res_o,
  output logic [StateW-1:0] state_d_o,
  output logic [CpW-1:0]    acc_d_o
);

  logic [ClassW-1:0] cls;
  logic [StateW-1:0] ns;
  logic [CpW-1:0]    acc_new;
  logic [7:0]        lead_mask;

  always_comb begin
    cls       = byte_class(item_i.data_byte);
    ns        = next_state(state_i, cls);
    lead_mask = 8'hFF >> cls;
    if (state_i != AcceptState) begin
      acc_new = {acc_i[CpW-7:0], item_i.data_byte[5:0]};
    end else begin
      acc_new = {{(CpW-8){1'b0}}, lead_mask & item_i.data_byte};
    end

    res_o.dfa_state       = ns;
    res_o.code_point      = acc_new;
    res_o.code_point_done = (ns == AcceptState);
    res_o.rejected        = (ns == RejectState);
    res_o.string_valid    = item_i.last_byte && (ns == AcceptState);

    // end of string closes the decoder back to accept
    state_d_o = item_i.last_byte ? AcceptState : ns;
    acc_d_o   = item_i.last_byte ? '0 : acc_new;
  end

endmodule

// ===== rtl/utf8_dfa_decoder.sv =====
// UTF-8 DFA decoder top level: input register, one step, result register.
// Throughput: 1 item per cycle while the output is ready, set by the decoder state
// loop through the class and transition tables.
// Reset: decoder state to accept, code point accumulator to zero, both stages empty.
// Depends on u8d_pkg, u8d_if, u8d_step.
module utf8_dfa_decoder import u8d_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  u8d_in_if.sink    in_i,
  u8d_out_if.source out_o
);

  u8d_item_t         item_q;
  logic              in_valid_q;
  u8d_res_t          res_q, res_d;
  logic              out_valid_q;
  logic [StateW-1:0] state_q, state_d;
  logic [CpW-1:0]    acc_q, acc_d;
  logic              adv;

  assign adv      = !out_valid_q || out_o.ready;
  assign in_i.ready = !in_valid_q || adv;

  u8d_step u_step (
    .state_i   (state_q),
    .acc_i     (acc_q),
    .item_i    (item_q),
    .res_o     (res_d),
    .state_d_o (state_d),
    .acc_d_o   (acc_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= AcceptState;
      acc_q       <= '0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (adv) begin
        out_valid_q <= in_valid_q;
        if (in_valid_q) begin
          state_q <= state_d;
          acc_q   <= acc_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q.data_byte <= in_i.data_byte;
      item_q.last_byte <= in_i.last_byte;
    end
    if (adv && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.dfa_state       = res_q.dfa_state;
  assign out_o.code_point      = res_q.code_point;
  assign out_o.code_point_done = res_q.code_point_done;
  assign out_o.rejected        = res_q.rejected;
  assign out_o.string_valid    = res_q.string_valid;

  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q < StateW'(NumStates))
    else $error("decoder state out of range");

  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_valid_q && item_q.last_byte) |=> (state_q == AcceptState && acc_q == '0))
    else $error("string end did not return decoder to accept");

  a_valid_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.string_valid) |-> (out_o.code_point_done && !out_o.rejected))
    else $error("valid string without completed code point");

  a_state_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_valid_q && !item_q.last_byte) |=> (state_q == res_q.dfa_state))
    else $error("decoder state differs from reported state");

endmodule

// ===== dv/testbench.sv =====
// Testbench for utf8_dfa_decoder: strings of bytes go in, and each result item is
// checked field by field against a scoreboard that runs its own copy of the decoder.
// Depends on u8d_pkg, u8d_if and the utf8_dfa_decoder RTL.
module testbench;
  import u8d_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 200;

  // transition rows, one nibble per class, class 0 in the low nibble
  localparam logic [63:0] DfaRows [NumStates] = '{
    64'h1111_6411_1785_3210,
    64'h1111_1111_1111_1111,
    64'h1111_1101_0111_1101,
    64'h1111_1121_2111_1121,
    64'h1111_1111_2111_1111,
    64'h1111_1121_1111_1121,
    64'h1111_1131_3111_1111,
    64'h1111_1131_3111_1131,
    64'h1111_1111_1111_1131
  };

  class utf8_scoreboard;
    logic [StateW-1:0] dfa_st;
    logic [CpW-1:0]    cp_acc;
    u8d_res_t          expected_q[$];
    int unsigned       n_err;
    int unsigned       n_ok;

    function new();
      dfa_st = AcceptState;
      cp_acc = '0;
      n_err  = 0;
      n_ok   = 0;
    endfunction

    function logic [ClassW-1:0] classify(logic [7:0] b);
      if (b < 8'h80) return ClsAscii;
      if (b < 8'h90) return ClsCont1;
      if (b < 8'hA0) return ClsCont2;
      if (b < 8'hC0) return ClsCont3;
      if (b < 8'hC2) return ClsBad;
      if (b < 8'hE0) return ClsLead2;
      if (b == 8'hE0) return ClsLeadE0;
      if (b == 8'hED) return ClsLeadED;
      if (b < 8'hF0) return ClsLead3;
      if (b == 8'hF0) return ClsLeadF0;
      if (b < 8'hF4) return ClsLead4;
      if (b == 8'hF4) return ClsLeadF4;
      return ClsBad;
    endfunction

    function void note_input(logic [7:0] b, logic last);
      u8d_res_t          r;
      logic [ClassW-1:0] cls;
      logic [63:0]       row;
      cls = classify(b);
      if (dfa_st != AcceptState) cp_acc = {cp_acc[CpW-7:0], b[5:0]};
      else cp_acc = CpW'((8'hFF >> cls) & b);
      if (dfa_st < StateW'(NumStates)) begin
        row    = DfaRows[dfa_st];
        dfa_st = row[cls*4 +: 4];
      end else begin
        dfa_st = RejectState;
      end
      r.dfa_state       = dfa_st;
      r.code_point      = cp_acc;
      r.code_point_done = (dfa_st == AcceptState);
      r.rejected        = (dfa_st == RejectState);
      r.string_valid    = last && (dfa_st == AcceptState);
      expected_q.push_back(r);
      if (last) begin
        dfa_st = AcceptState;
        cp_acc = '0;
      end
    endfunction

    function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        n_err++;
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_result(u8d_res_t got);
      u8d_res_t want;
      bit       ok;
      if (expected_q.size() == 0) begin
        $error("result item with nothing expected: dfa_state %0d code_point 0x%0h",
               got.dfa_state, got.code_point);
        n_err++;
        return;
      end
      want = expected_q.pop_front();
      ok = field_ok("dfa_state", 32'(want.dfa_state), 32'(got.dfa_state));
      ok &= field_ok("code_point", want.code_point, got.code_point);
      ok &= field_ok("code_point_done", 32'(want.code_point_done), 32'(got.code_point_done));
      ok &= field_ok("rejected", 32'(want.rejected), 32'(got.rejected));
      ok &= field_ok("string_valid", 32'(want.string_valid), 32'(got.string_valid));
      if (ok) n_ok++;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  bit          idle_on;
  int unsigned hold_req;
  int unsigned cycles;
  int unsigned n_bytes;
  int unsigned n_strings;
  logic [7:0]  str_q[$];
  utf8_scoreboard sb;

  u8d_in_if  byte_if ();
  u8d_out_if res_if ();

  utf8_dfa_decoder dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (byte_if),
    .out_o  (res_if)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               sb.expected_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && sb != null) begin
      if (byte_if.valid && byte_if.ready) sb.note_input(byte_if.data_byte, byte_if.last_byte);
      if (res_if.valid && res_if.ready)
        sb.check_result(u8d_res_t'{res_if.dfa_state, res_if.code_point,
                                   res_if.code_point_done, res_if.rejected,
                                   res_if.string_valid});
    end
  end

  // result side: random stalls while idle_on is set, plus a long hold-off each time hold_req is bumped
  initial begin
    int unsigned served;
    int unsigned left;
    served = 0;
    left   = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (left == 0 && served != hold_req) begin
        served = hold_req;
        left   = HoldCycles;
      end
      if (left != 0) begin
        left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= !idle_on || ($urandom_range(99) >= 25);
      end
    end
  end

  // while idle_on is set, a random idle gap before about one item in eight keeps the input idle ~25% of cycles
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(99) < 13) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= b;
    byte_if.last_byte <= last;
    do @(posedge clk); while (!byte_if.ready);
    n_bytes++;
  endtask

  task automatic send_str();
    foreach (str_q[i]) send_byte(str_q[i], i == str_q.size() - 1);
    str_q.delete();
    n_strings++;
  endtask

  function automatic void add_cp(logic [31:0] cp);
    if (cp < 32'h80) begin
      str_q.push_back(cp[7:0]);
    end else if (cp < 32'h800) begin
      str_q.push_back({3'b110, cp[10:6]});
      str_q.push_back({2'b10, cp[5:0]});
    end else if (cp < 32'h10000) begin
      str_q.push_back({4'b1110, cp[15:12]});
      str_q.push_back({2'b10, cp[11:6]});
      str_q.push_back({2'b10, cp[5:0]});
    end else begin
      str_q.push_back({5'b11110, cp[20:18]});
      str_q.push_back({2'b10, cp[17:12]});
      str_q.push_back({2'b10, cp[11:6]});
      str_q.push_back({2'b10, cp[5:0]});
    end
  endfunction

  function automatic logic [31:0] random_cp();
    logic [31:0] cp;
    case ($urandom_range(3))
      0: cp = $urandom_range(32'h7F, 0);
      1: cp = $urandom_range(32'h7FF, 32'h80);
      2: begin
        do cp = $urandom_range(32'hFFFF, 32'h800);
        while (cp >= 32'hD800 && cp <= 32'hDFFF);
      end
      default: cp = $urandom_range(32'h10FFFF, 32'h10000);
    endcase
    return cp;
  endfunction

  // mostly well-formed strings; some raw noise, cut-off sequences, stray continuations
  task automatic random_strings(input int unsigned count);
    int unsigned start;
    int unsigned pick;
    start = n_bytes;
    while (n_bytes - start < count) begin
      repeat ($urandom_range(1, 6)) begin
        pick = $urandom_range(99);
        if (pick < 80) begin
          add_cp(random_cp());
        end else if (pick < 90) begin
          str_q.push_back(8'($urandom_range(255)));
        end else if (pick < 95) begin
          add_cp(random_cp());
          if (str_q.size() > 1) void'(str_q.pop_back());
        end else begin
          str_q.push_back(8'($urandom_range(8'hBF, 8'h80)));
        end
      end
      send_str();
    end
  endtask

  initial begin
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    byte_if.last_byte = 1'b0;
    rst_n     = 1'b0;
    idle_on   = 1'b1;
    hold_req  = 0;
    n_bytes   = 0;
    n_strings = 0;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    str_q = '{8'h00, 8'h7F};                 send_str();
    str_q = '{8'hC2, 8'h80};                 send_str();
    str_q = '{8'hE0, 8'hA0, 8'h80};          send_str();
    str_q = '{8'hED, 8'h9F, 8'hBF};          send_str();
    str_q = '{8'hF0, 8'h90, 8'h80, 8'h80};   send_str();
    str_q = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};   send_str();
    // string ends inside a sequence
    str_q = '{8'hE1, 8'h80};                 send_str();
    str_q = '{8'hC0, 8'hFF};                 send_str();
    // stray continuation, then reject keeps shifting until the accumulator wraps
    str_q = '{8'h8F, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF}; send_str();

    random_strings(150);
    idle_on = 1'b0;
    random_strings(100);
    hold_req++;
    random_strings(60);
    idle_on = 1'b1;
    random_strings(200);
    byte_if.valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Covered %0d bytes in %0d strings: table extremes, bad and truncated sequences,",
             n_bytes, n_strings);
    $display("accumulator wrap, random stalls and a %0d-cycle output hold; %0d results matched",
             HoldCycles, sb.n_ok);
    if (sb.n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
